>>> design/arpc_pkg.sv
// shared types and constants for the arp cache and responder
package arpc_pkg;

   localparam int MAC_BYTES = 6;
   localparam int MAC_W     = 8 * MAC_BYTES;
   localparam int IP_W      = 32;
   localparam int HALF_W    = 16;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = MAC_W;

   localparam logic [HALF_W-1:0] HW_ETHERNET = 16'h0001;
   localparam logic [HALF_W-1:0] PROTO_IPV4  = 16'h0800;
   localparam logic [HALF_W-1:0] OP_REQUEST  = 16'h0001;
   localparam logic [HALF_W-1:0] OP_REPLY    = 16'h0002;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MAC = 8'd1;

   typedef enum logic [2:0] {
      OUT_BAD_HW    = 3'd0,
      OUT_BAD_PROTO = 3'd1,
      OUT_UPDATED   = 3'd2,
      OUT_INSERTED  = 3'd3,
      OUT_FULL      = 3'd4,
      OUT_NOT_OURS  = 3'd5
   } outcome_type;

   typedef struct packed {
      logic        accept;
      logic        scan_start;
      logic        scan_en;
      logic        store;
      logic        insert;
      logic        load_result;
      outcome_type outcome;
      logic        send_reply;
   } cmd_type;

   typedef struct packed {
      logic hw_ok;
      logic proto_ok;
      logic empty;
      logic full;
      logic hit_now;
      logic miss_done;
      logic hit;
      logic tgt_ours;
      logic is_request;
      logic out_free;
   } status_type;

endpackage

>>> design/arpc_ctrl.sv
// controller state machine: sequences check, cache scan, write-back and result
module arpc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  arpc_pkg::status_type status,
   output arpc_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_SPARE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.outcome     = arpc_pkg::OUT_NOT_OURS;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.hw_ok) begin
               if (status.out_free) begin
                  cmd.load_result = 1'b1;
                  cmd.outcome     = arpc_pkg::OUT_BAD_HW;
                  state_in        = ST_IDLE;
               end
            end else if (!status.proto_ok) begin
               if (status.out_free) begin
                  cmd.load_result = 1'b1;
                  cmd.outcome     = arpc_pkg::OUT_BAD_PROTO;
                  state_in        = ST_IDLE;
               end
            end else begin
               // an empty cache needs no scan, the hit flag is cleared here
               cmd.scan_start = 1'b1;
               state_in       = status.empty ? ST_DECIDE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (status.hit_now || status.miss_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.out_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
               if (!status.tgt_ours) begin
                  cmd.outcome = arpc_pkg::OUT_NOT_OURS;
                  cmd.store   = status.hit;
               end else begin
                  cmd.send_reply = status.is_request;
                  if (status.hit) begin
                     cmd.outcome = arpc_pkg::OUT_UPDATED;
                     cmd.store   = 1'b1;
                  end else if (status.full) begin
                     cmd.outcome = arpc_pkg::OUT_FULL;
                  end else begin
                     cmd.outcome = arpc_pkg::OUT_INSERTED;
                     cmd.store   = 1'b1;
                     cmd.insert  = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/arpc_dp.sv
// datapath: item registers, config registers, cache memories, scan and result register
module arpc_dp #(
   parameter int CACHE_ENTRIES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  arpc_pkg::cmd_type                   cmd,
   output arpc_pkg::status_type                status,
   input  logic [arpc_pkg::HALF_W-1:0]         req_hw_type,
   input  logic [arpc_pkg::HALF_W-1:0]         req_proto_type,
   input  logic [arpc_pkg::HALF_W-1:0]         req_operation,
   input  logic [arpc_pkg::MAC_W-1:0]          req_sender_mac,
   input  logic [arpc_pkg::IP_W-1:0]           req_sender_ip,
   input  logic [arpc_pkg::IP_W-1:0]           req_target_ip,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [arpc_pkg::CSR_DAT_W-1:0]      csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_outcome,
   output logic                                rsp_send_reply,
   output logic [arpc_pkg::MAC_W-1:0]          rsp_reply_target_mac,
   output logic [arpc_pkg::IP_W-1:0]           rsp_reply_target_ip
);

   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] DEPTH = CNT_W'(CACHE_ENTRIES);

   // item registers
   logic [arpc_pkg::HALF_W-1:0] hw_ff, proto_ff, op_ff;
   logic [arpc_pkg::MAC_W-1:0]  smac_ff;
   logic [arpc_pkg::IP_W-1:0]   sip_ff, tip_ff;

   logic [arpc_pkg::IP_W-1:0]   own_ip_ff;
   logic [arpc_pkg::MAC_W-1:0]  own_mac_ff;

   // cache: entries below the fill count are valid, inserts always go to the fill count
   logic [arpc_pkg::IP_W-1:0]   ip_mem  [CACHE_ENTRIES];
   logic [arpc_pkg::MAC_W-1:0]  mac_mem [CACHE_ENTRIES];
   logic [CNT_W-1:0]            count_ff;

   logic [CNT_W-1:0]            addr_ff, addr_q_ff;
   logic                        rd_vld_ff;
   logic [arpc_pkg::IP_W-1:0]   rd_ip_ff;
   logic                        hit_ff;
   logic [IDX_W-1:0]            hit_idx_ff;
   logic                        issue;
   logic                        match;
   logic [IDX_W-1:0]            wr_idx;

   logic                        rsp_valid_ff;
   arpc_pkg::outcome_type       outcome_ff;
   logic                        reply_ff;
   logic [arpc_pkg::MAC_W-1:0]  rmac_ff;
   logic [arpc_pkg::IP_W-1:0]   rip_ff;

   assign csr_ready = 1'b1;
   assign issue     = cmd.scan_en && (addr_ff < count_ff);
   assign match     = (rd_ip_ff == sip_ff);
   assign wr_idx    = cmd.insert ? count_ff[IDX_W-1:0] : hit_idx_ff;

   assign status.hw_ok      = (hw_ff == arpc_pkg::HW_ETHERNET);
   assign status.proto_ok   = (proto_ff == arpc_pkg::PROTO_IPV4);
   assign status.empty      = (count_ff == '0);
   assign status.full       = (count_ff == DEPTH);
   assign status.hit_now    = rd_vld_ff && match;
   assign status.miss_done  = rd_vld_ff && !match
                              && (addr_q_ff == CNT_W'(count_ff - 1'b1));
   assign status.hit        = hit_ff;
   assign status.tgt_ours   = (tip_ff == own_ip_ff);
   assign status.is_request = (op_ff == arpc_pkg::OP_REQUEST);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hw_ff    <= req_hw_type;
         proto_ff <= req_proto_type;
         op_ff    <= req_operation;
         smac_ff  <= req_sender_mac;
         sip_ff   <= req_sender_ip;
         tip_ff   <= req_target_ip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff  <= '0;
         own_mac_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            arpc_pkg::CSR_OWN_IP:  own_ip_ff  <= csr_wdata[arpc_pkg::IP_W-1:0];
            arpc_pkg::CSR_OWN_MAC: own_mac_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // memories: one registered read port for the scan, one write port
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ip_ff <= ip_mem[addr_ff[IDX_W-1:0]];
      end
      if (cmd.store) begin
         ip_mem[wr_idx]  <= sip_ff;
         mac_mem[wr_idx] <= smac_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         if (cmd.insert) begin
            count_ff <= CNT_W'(count_ff + 1'b1);
         end
         if (cmd.scan_start) begin
            addr_ff   <= '0;
            rd_vld_ff <= 1'b0;
            hit_ff    <= 1'b0;
         end else if (cmd.scan_en) begin
            rd_vld_ff <= issue;
            if (issue) begin
               addr_ff <= CNT_W'(addr_ff + 1'b1);
            end
            // compares arrive in index order, so the first hit is the lowest
            if (rd_vld_ff && match) begin
               hit_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         addr_q_ff <= addr_ff;
      end
      if (cmd.scan_en && rd_vld_ff && match) begin
         hit_idx_ff <= addr_q_ff[IDX_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         outcome_ff <= cmd.outcome;
         reply_ff   <= cmd.send_reply;
         rmac_ff    <= cmd.send_reply ? smac_ff : '0;
         rip_ff     <= cmd.send_reply ? sip_ff : '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_outcome          = outcome_ff;
   assign rsp_send_reply       = reply_ff;
   assign rsp_reply_target_mac = rmac_ff;
   assign rsp_reply_target_ip  = rip_ff;

   // own_mac is the sender address of replies, assembled downstream
   logic own_mac_unused;
   assign own_mac_unused = ^own_mac_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH)
      else $error("fill count beyond cache depth");

   a_insert_step: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("fill count did not advance on insert");

   a_no_insert_on_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !hit_ff && (count_ff != DEPTH))
      else $error("insert on hit or into a full cache");

   a_reply_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && reply_ff |-> outcome_ff == arpc_pkg::OUT_UPDATED
         || outcome_ff == arpc_pkg::OUT_INSERTED || outcome_ff == arpc_pkg::OUT_FULL)
      else $error("reply with an outcome that forbids one");

endmodule

>>> design/arp_cache_and_responder_core.sv
// arp cache and responder top level: controller and datapath
// sequence: type checks, then a scan of the cache that stops at the first hit or after the last valid
//    entry, skipped when the cache is empty or a type check fails, then the result register is loaded
// one item at a time: req_stall holds off a new item until the result is loaded, so the scan sets the rate
// reset: own_ip and own_mac clear to zero, the fill count clears so the cache is empty
// reset needs no clearing pass, a result waiting in the output register is dropped
module arp_cache_and_responder_core #(
   parameter int CACHE_ENTRIES = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [arpc_pkg::HALF_W-1:0]      req_hw_type,
   input  logic [arpc_pkg::HALF_W-1:0]      req_proto_type,
   input  logic [arpc_pkg::HALF_W-1:0]      req_operation,
   input  logic [arpc_pkg::MAC_W-1:0]       req_sender_mac,
   input  logic [arpc_pkg::IP_W-1:0]        req_sender_ip,
   input  logic [arpc_pkg::IP_W-1:0]        req_target_ip,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_outcome,
   output logic                             rsp_send_reply,
   output logic [arpc_pkg::MAC_W-1:0]       rsp_reply_target_mac,
   output logic [arpc_pkg::IP_W-1:0]        rsp_reply_target_ip,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [arpc_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   arpc_pkg::cmd_type    cmd;
   arpc_pkg::status_type status;

   arpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   arpc_dp #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_hw_type          (req_hw_type),
      .req_proto_type       (req_proto_type),
      .req_operation        (req_operation),
      .req_sender_mac       (req_sender_mac),
      .req_sender_ip        (req_sender_ip),
      .req_target_ip        (req_target_ip),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_outcome          (rsp_outcome),
      .rsp_send_reply       (rsp_send_reply),
      .rsp_reply_target_mac (rsp_reply_target_mac),
      .rsp_reply_target_ip  (rsp_reply_target_ip)
   );

endmodule

>>> tb/arp_cache_and_responder_core_tb.sv
// self-checking testbench for the arp cache and responder core
`timescale 1ns / 100ps

module arp_cache_and_responder_core_tb;

   localparam int CACHE_ENTRIES = 32;
   localparam int IP_POOL_SIZE  = 40;
   localparam int PHASE_ITEMS   = 500;
   localparam int SETTLE_CYCLES = CACHE_ENTRIES + 8;
   localparam int HOLD_AT       = 150;
   localparam int HOLD_LEN      = 400;

   // indexes past the register list, the block must ignore them
   localparam logic [arpc_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = arpc_pkg::CSR_OWN_MAC + 1'b1;
   localparam logic [arpc_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = '1;

   localparam logic [arpc_pkg::HALF_W-1:0] ETHERTYPE_ARP = 16'h0806;

   typedef struct packed {
      logic [arpc_pkg::HALF_W-1:0] hw_type;
      logic [arpc_pkg::HALF_W-1:0] proto_type;
      logic [arpc_pkg::HALF_W-1:0] operation;
      logic [arpc_pkg::MAC_W-1:0]  sender_mac;
      logic [arpc_pkg::IP_W-1:0]   sender_ip;
      logic [arpc_pkg::IP_W-1:0]   target_ip;
   } packet_type;

   typedef struct packed {
      arpc_pkg::outcome_type      outcome;
      logic                       send_reply;
      logic [arpc_pkg::MAC_W-1:0] target_mac;
      logic [arpc_pkg::IP_W-1:0]  target_ip;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   packet_type drv_pkt   = '0;

   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [2:0]                 rsp_outcome;
   logic                       rsp_send_reply;
   logic [arpc_pkg::MAC_W-1:0] rsp_reply_target_mac;
   logic [arpc_pkg::IP_W-1:0]  rsp_reply_target_ip;

   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [arpc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [arpc_pkg::CSR_DAT_W-1:0] csr_wdata = '0;

   // shadow of the block's registers and cache
   logic [arpc_pkg::IP_W-1:0]  shadow_ip  = '0;
   logic [arpc_pkg::MAC_W-1:0] shadow_mac = '0;
   bit                         cache_valid [CACHE_ENTRIES];
   logic [arpc_pkg::IP_W-1:0]  cache_ip    [CACHE_ENTRIES];
   logic [arpc_pkg::MAC_W-1:0] cache_mac   [CACHE_ENTRIES];

   packet_type pending_packets[$];
   result_type awaited_results[$];
   result_type want_result;

   logic [arpc_pkg::IP_W-1:0] ip_pool [IP_POOL_SIZE];
   bit              idle_gaps   = 1'b1;
   int              send_gap    = 0;
   int              stall_left  = 0;
   int              taken_count = 0;
   int              fail_count  = 0;

   arp_cache_and_responder_core #(
      .CACHE_ENTRIES(CACHE_ENTRIES)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_hw_type          (drv_pkt.hw_type),
      .req_proto_type       (drv_pkt.proto_type),
      .req_operation        (drv_pkt.operation),
      .req_sender_mac       (drv_pkt.sender_mac),
      .req_sender_ip        (drv_pkt.sender_ip),
      .req_target_ip        (drv_pkt.target_ip),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_outcome          (rsp_outcome),
      .rsp_send_reply       (rsp_send_reply),
      .rsp_reply_target_mac (rsp_reply_target_mac),
      .rsp_reply_target_ip  (rsp_reply_target_ip),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   // rfc 826 reception: merge on a hit, insert only when the packet targets us
   function automatic result_type resolve_packet(packet_type p);
      result_type r;
      int         hit_idx;
      int         free_idx;
      int         i;
      r        = '0;
      hit_idx  = -1;
      free_idx = -1;
      if (p.hw_type != arpc_pkg::HW_ETHERNET) begin
         r.outcome = arpc_pkg::OUT_BAD_HW;
         return r;
      end
      if (p.proto_type != arpc_pkg::PROTO_IPV4) begin
         r.outcome = arpc_pkg::OUT_BAD_PROTO;
         return r;
      end
      for (i = 0; i < CACHE_ENTRIES; i++)
         if (hit_idx < 0 && cache_valid[i] && cache_ip[i] == p.sender_ip)
            hit_idx = i;
      if (hit_idx >= 0)
         cache_mac[hit_idx] = p.sender_mac;
      if (p.target_ip != shadow_ip) begin
         r.outcome = arpc_pkg::OUT_NOT_OURS;
         return r;
      end
      if (hit_idx >= 0) begin
         r.outcome = arpc_pkg::OUT_UPDATED;
      end else begin
         for (i = 0; i < CACHE_ENTRIES; i++)
            if (free_idx < 0 && !cache_valid[i])
               free_idx = i;
         if (free_idx < 0) begin
            r.outcome = arpc_pkg::OUT_FULL;
         end else begin
            cache_valid[free_idx] = 1'b1;
            cache_ip[free_idx]    = p.sender_ip;
            cache_mac[free_idx]   = p.sender_mac;
            r.outcome             = arpc_pkg::OUT_INSERTED;
         end
      end
      if (p.operation == arpc_pkg::OP_REQUEST) begin
         r.send_reply = 1'b1;
         r.target_mac = p.sender_mac;
         r.target_ip  = p.sender_ip;
      end
      return r;
   endfunction

   function automatic packet_type build_packet(logic [arpc_pkg::HALF_W-1:0] hw,
                                               logic [arpc_pkg::HALF_W-1:0] proto,
                                               logic [arpc_pkg::HALF_W-1:0] op,
                                               logic [arpc_pkg::MAC_W-1:0]  smac,
                                               logic [arpc_pkg::IP_W-1:0]   sip,
                                               logic [arpc_pkg::IP_W-1:0]   tip);
      packet_type p;
      p.hw_type    = hw;
      p.proto_type = proto;
      p.operation  = op;
      p.sender_mac = smac;
      p.sender_ip  = sip;
      p.target_ip  = tip;
      return p;
   endfunction

   function automatic logic [arpc_pkg::MAC_W-1:0] random_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // mostly well-formed packets from a small sender pool so the cache fills up
   function automatic packet_type random_packet();
      packet_type p;
      int         sel;
      p.hw_type    = arpc_pkg::HW_ETHERNET;
      p.proto_type = arpc_pkg::PROTO_IPV4;
      sel = $urandom_range(0, 99);
      if (sel < 6)
         p.hw_type = 16'($urandom);
      else if (sel < 12)
         p.proto_type = 16'($urandom);
      case ($urandom_range(0, 3))
         0, 1:    p.operation = arpc_pkg::OP_REQUEST;
         2:       p.operation = arpc_pkg::OP_REPLY;
         default: p.operation = 16'($urandom);
      endcase
      p.sender_mac = random_mac();
      p.sender_ip  = ($urandom_range(0, 9) == 0) ? $urandom
                                                 : ip_pool[$urandom_range(0, IP_POOL_SIZE-1)];
      if ($urandom_range(0, 3) != 0)
         p.target_ip = shadow_ip;
      else if ($urandom_range(0, 1) == 0)
         p.target_ip = $urandom;
      else
         p.target_ip = ip_pool[$urandom_range(0, IP_POOL_SIZE-1)];
      return p;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic write_reg(logic [arpc_pkg::CSR_IDX_W-1:0] idx,
                            logic [arpc_pkg::CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == arpc_pkg::CSR_OWN_IP)
         shadow_ip = val[arpc_pkg::IP_W-1:0];
      else if (idx == arpc_pkg::CSR_OWN_MAC)
         shadow_mac = val;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_packets.size() != 0 || req_valid || awaited_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // sender: one item per handshake, random gap after each item while idle gaps are enabled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            awaited_results.push_back(resolve_packet(drv_pkt));
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_packets.size() != 0) begin
            drv_pkt   <= pending_packets.pop_front();
            req_valid <= 1'b1;
            send_gap  <= idle_gaps ? $urandom_range(0, 3) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            taken_count++;
            if (taken_count == HOLD_AT)
               stall_left = HOLD_LEN;
            else
               stall_left = idle_gaps ? $urandom_range(0, 3) : 0;
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected item", 64'(rsp_outcome), 64'(0));
         end else begin
            want_result = awaited_results.pop_front();
            if (rsp_outcome !== want_result.outcome)
               report_mismatch("outcome", 64'(rsp_outcome), 64'(want_result.outcome));
            if (rsp_send_reply !== want_result.send_reply)
               report_mismatch("send_reply", 64'(rsp_send_reply),
                               64'(want_result.send_reply));
            if (rsp_reply_target_mac !== want_result.target_mac)
               report_mismatch("reply_target_mac", 64'(rsp_reply_target_mac),
                               64'(want_result.target_mac));
            if (rsp_reply_target_ip !== want_result.target_ip)
               report_mismatch("reply_target_ip", 64'(rsp_reply_target_ip),
                               64'(want_result.target_ip));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [arpc_pkg::IP_W-1:0]  ip_a;
      logic [arpc_pkg::IP_W-1:0]  ip_b;
      logic [arpc_pkg::IP_W-1:0]  ip_c;
      logic [arpc_pkg::MAC_W-1:0] all_ones;
      int                         ph;
      all_ones = '1;
      ip_a     = $urandom;
      ip_b     = $urandom;
      ip_c     = $urandom;
      ip_pool[0] = '0;
      ip_pool[1] = '1;
      for (int k = 2; k < IP_POOL_SIZE; k++)
         ip_pool[k] = $urandom;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers at reset value: own ip is zero
      pending_packets.push_back(build_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                             arpc_pkg::OP_REQUEST, '0, '0, '0));
      pending_packets.push_back(build_packet('0, arpc_pkg::PROTO_IPV4, arpc_pkg::OP_REQUEST,
                                             random_mac(), '0, '0));
      pending_packets.push_back(build_packet('1, '1, '1, all_ones, '1, '1));
      pending_packets.push_back(build_packet(arpc_pkg::HW_ETHERNET, '0, arpc_pkg::OP_REQUEST,
                                             random_mac(), '0, '0));
      pending_packets.push_back(build_packet(arpc_pkg::HW_ETHERNET, '1, arpc_pkg::OP_REQUEST,
                                             random_mac(), '0, '0));
      pending_packets.push_back(build_packet(arpc_pkg::HW_ETHERNET, ETHERTYPE_ARP,
                                             arpc_pkg::OP_REQUEST, random_mac(), ip_a, '0));
      wait_drained();

      write_reg(arpc_pkg::CSR_OWN_IP,
                {{(arpc_pkg::CSR_DAT_W-arpc_pkg::IP_W){1'b0}}, {arpc_pkg::IP_W{1'b1}}});
      write_reg(arpc_pkg::CSR_OWN_MAC, all_ones);
      write_reg(CSR_SPARE_LO, random_mac());
      write_reg(CSR_SPARE_HI, all_ones);
      @(negedge clock);

      // known sender refreshed, then inserts under the reply opcode and the all-zero and all-ones opcodes
      pending_packets.push_back(build_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                             arpc_pkg::OP_REQUEST, all_ones, '0, '1));
      pending_packets.push_back(build_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                             arpc_pkg::OP_REPLY, random_mac(), '1, '1));
      pending_packets.push_back(build_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                             '0, random_mac(), ip_a, '1));
      pending_packets.push_back(build_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                             '1, random_mac(), ip_b, '1));
      // foreign target: refresh on a hit, no insert on a miss, never a reply
      pending_packets.push_back(build_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                             arpc_pkg::OP_REQUEST, random_mac(), ip_a, '0));
      pending_packets.push_back(build_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                             arpc_pkg::OP_REQUEST, random_mac(), ip_c,
                                             $urandom));
      pending_packets.push_back(build_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                             arpc_pkg::OP_REQUEST, random_mac(), ip_c, '1));
      pending_packets.push_back(build_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                             arpc_pkg::OP_REQUEST, '0, '1, '1));
      pending_packets.push_back(build_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                             arpc_pkg::OP_REPLY, random_mac(), ip_b, '1));

      for (ph = 0; ph < 4; ph++) begin
         wait_drained();
         // third phase runs back to back with no idling on either side
         idle_gaps = (ph != 2);
         case (ph)
            0: begin
               write_reg(arpc_pkg::CSR_OWN_IP,
                         {{(arpc_pkg::CSR_DAT_W-arpc_pkg::IP_W){1'b0}}, ip_pool[5]});
               write_reg(arpc_pkg::CSR_OWN_MAC, random_mac());
            end
            1: begin
               write_reg(arpc_pkg::CSR_OWN_IP, '0);
               write_reg(arpc_pkg::CSR_OWN_MAC, '0);
            end
            2: begin
               write_reg(arpc_pkg::CSR_OWN_IP, all_ones);
               write_reg(arpc_pkg::CSR_OWN_MAC, all_ones);
            end
            default: begin
               write_reg(arpc_pkg::CSR_OWN_IP, random_mac());
               write_reg(arpc_pkg::CSR_OWN_MAC, random_mac());
               write_reg(CSR_SPARE_LO, random_mac());
            end
         endcase
         @(negedge clock);
         repeat (PHASE_ITEMS) pending_packets.push_back(random_packet());
      end

      wait_drained();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
